// ----- hdl/vpiq_pkg.sv -----
// ----------------------------------------------------------------------------
// vpiq_pkg
// Shared types, codes and constants of the validated priority ingress queue.
// ----------------------------------------------------------------------------
package vpiq_pkg;

   localparam int NUM_QUEUES         = 5;
   localparam int QIDX_W             = 3;
   localparam int LAST_SOURCE_CODE   = 5;
   localparam int MAX_TYPE_CODE      = 7;
   localparam int DEF_QUEUE_DEPTH    = 8;
   localparam int DEF_PAYLOAD_WIDTH  = 32;

   localparam int SRC_W   = 4;
   localparam int TYPE_W  = 4;
   localparam int STAMP_W = 48;
   localparam int SCHEMA_W = 8;
   localparam int SEQ_W   = 32;
   localparam int PAY_W   = 32;
   localparam int ID_W    = 32;
   localparam int AGE_W   = 32;
   localparam int LIMIT_W = 4;
   localparam int OCC_W   = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [QIDX_W-1:0] OTHER_QUEUE = 3'd4;

   localparam logic [SCHEMA_W-1:0] RST_EXPECTED_SCHEMA = 8'd1;
   localparam logic [AGE_W-1:0]    RST_SAFETY_MAX_AGE  = 32'd100;
   localparam logic [AGE_W-1:0]    RST_DEFAULT_MAX_AGE = 32'd1000;
   localparam logic [LIMIT_W-1:0]  RST_QUEUE_LIMIT     = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXPECTED_SCHEMA = 2'd0,
      CSR_SAFETY_MAX_AGE  = 2'd1,
      CSR_DEFAULT_MAX_AGE = 2'd2,
      CSR_QUEUE_LIMIT     = 2'd3
   } csr_index_type;

   typedef enum logic {
      REQ_PUSH = 1'b0,
      REQ_POLL = 1'b1
   } req_kind_type;

   typedef enum logic {
      KIND_STATUS = 1'b0,
      KIND_ENTRY  = 1'b1
   } rsp_kind_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_INVALID  = 2'd1,
      ST_STALE    = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RC_IGNORE    = 2'd0,
      RC_SAFE_STOP = 2'd1,
      RC_RETRY     = 2'd2
   } recovery_type;

   typedef struct packed {
      logic               bad;
      logic               safety;
      logic               late;
      logic [STAMP_W-1:0] age;
   } screen_type;

endpackage

// ----- hdl/vpiq_screen.sv -----
// ----------------------------------------------------------------------------
// vpiq_screen
// Field checks and age difference of a push beat, registered on capture.
// ----------------------------------------------------------------------------
module vpiq_screen (
   input  logic                             clock,
   input  logic                             load,
   input  logic [vpiq_pkg::SRC_W-1:0]       source,
   input  logic [vpiq_pkg::TYPE_W-1:0]      msg_type,
   input  logic [vpiq_pkg::STAMP_W-1:0]     stamp,
   input  logic [vpiq_pkg::STAMP_W-1:0]     now_time,
   input  logic [vpiq_pkg::SCHEMA_W-1:0]    schema,
   input  logic [vpiq_pkg::SEQ_W-1:0]       seq_no,
   input  logic                             payload_present,
   input  logic [vpiq_pkg::SCHEMA_W-1:0]    expected_schema,
   output vpiq_pkg::screen_type             screen
);

   vpiq_pkg::screen_type            screen_ff;
   vpiq_pkg::screen_type            screen_in;
   logic [vpiq_pkg::STAMP_W:0]      diff;

   always_comb begin
      diff = {1'b0, now_time} - {1'b0, stamp};
      screen_in.bad = (source > vpiq_pkg::SRC_W'(vpiq_pkg::LAST_SOURCE_CODE)) ||
                      (msg_type > vpiq_pkg::TYPE_W'(vpiq_pkg::MAX_TYPE_CODE)) ||
                      (stamp == '0) || (schema != expected_schema) ||
                      (seq_no == '0) || !payload_present;
      screen_in.safety = (source == '0);
      screen_in.late   = diff[vpiq_pkg::STAMP_W];
      screen_in.age    = diff[vpiq_pkg::STAMP_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         screen_ff <= screen_in;
      end
   end

   assign screen = screen_ff;

endmodule

// ----- hdl/validated_priority_ingress_queue_unit.sv -----
// ----------------------------------------------------------------------------
// validated_priority_ingress_queue_unit
// Validates push beats, stores valid ones in five class queues held in one
// entry memory, and drains all queues in priority order on a poll.
// ----------------------------------------------------------------------------
// Push: capture and screen the beat, then decide and write memory in S_DECIDE;
//   result registered on leaving S_DECIDE, which waits while the response is held.
// Poll: capture, then one entry per cycle through the registered memory read
//   while the response is not held; with no entries stored, one non-valid entry.
// Reset: synchronous; clears queue heads, counts, occupancy, id counter and
//   registers to defaults. Entry memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module validated_priority_ingress_queue_unit #(
   parameter int QUEUE_DEPTH   = vpiq_pkg::DEF_QUEUE_DEPTH,
   parameter int PAYLOAD_WIDTH = vpiq_pkg::DEF_PAYLOAD_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [vpiq_pkg::SRC_W-1:0]          req_source,
   input  logic [vpiq_pkg::TYPE_W-1:0]         req_msg_type,
   input  logic [vpiq_pkg::STAMP_W-1:0]        req_stamp,
   input  logic [vpiq_pkg::STAMP_W-1:0]        req_now_time,
   input  logic [vpiq_pkg::SCHEMA_W-1:0]       req_schema,
   input  logic [vpiq_pkg::SEQ_W-1:0]          req_seq_no,
   input  logic                                req_payload_present,
   input  logic [vpiq_pkg::PAY_W-1:0]          req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [1:0]                          rsp_status,
   output logic [1:0]                          rsp_recovery,
   output logic                                rsp_entry_valid,
   output logic [vpiq_pkg::ID_W-1:0]           rsp_entry_id,
   output logic [vpiq_pkg::SRC_W-1:0]          rsp_entry_source,
   output logic [vpiq_pkg::TYPE_W-1:0]         rsp_entry_type,
   output logic [vpiq_pkg::STAMP_W-1:0]        rsp_entry_stamp,
   output logic [vpiq_pkg::PAY_W-1:0]          rsp_entry_payload,
   output logic                                rsp_last,
   output logic [vpiq_pkg::OCC_W-1:0]          rsp_occupancy,
   input  logic                                csr_we,
   input  logic [vpiq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vpiq_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NQ      = vpiq_pkg::NUM_QUEUES;
   localparam int QW      = vpiq_pkg::QIDX_W;
   localparam int ENTRIES = NQ * QUEUE_DEPTH;
   localparam int AW      = $clog2(ENTRIES);
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW      = $clog2(QUEUE_DEPTH + 1);
   localparam int LW      = (CW > vpiq_pkg::LIMIT_W) ? CW : vpiq_pkg::LIMIT_W;
   localparam int TW      = ((PTR_W > CW) ? PTR_W : CW) + 1;
   localparam int OW0     = $clog2(ENTRIES + 1);
   localparam int OW      = (OW0 > vpiq_pkg::OCC_W) ? OW0 : vpiq_pkg::OCC_W;
   localparam int PS_W    = (PAYLOAD_WIDTH < vpiq_pkg::PAY_W) ? PAYLOAD_WIDTH
                                                              : vpiq_pkg::PAY_W;
   localparam int CODE_LSB  = 0;
   localparam int PAY_LSB   = CODE_LSB + vpiq_pkg::SRC_W + vpiq_pkg::TYPE_W;
   localparam int STAMP_LSB = PAY_LSB + PS_W;
   localparam int ID_LSB    = STAMP_LSB + vpiq_pkg::STAMP_W;
   localparam int EW        = ID_LSB + vpiq_pkg::ID_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECIDE = 5'b00010,
      S_EMPTY  = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_FLUSH  = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;

   logic [vpiq_pkg::SCHEMA_W-1:0]      exp_schema_ff;
   logic [vpiq_pkg::AGE_W-1:0]         safety_age_ff;
   logic [vpiq_pkg::AGE_W-1:0]         default_age_ff;
   logic [vpiq_pkg::LIMIT_W-1:0]       limit_ff;

   logic [PTR_W-1:0]                   heads_ff [NQ];
   logic [PTR_W-1:0]                   heads_in [NQ];
   logic [CW-1:0]                      counts_ff [NQ];
   logic [CW-1:0]                      counts_in [NQ];
   logic [vpiq_pkg::ID_W-1:0]          id_ff, id_in;
   logic [OW-1:0]                      occ_ff, occ_in;

   logic [QW-1:0]                      q_ff;
   logic [vpiq_pkg::SRC_W-1:0]         src_ff;
   logic [vpiq_pkg::TYPE_W-1:0]        typ_ff;
   logic [vpiq_pkg::STAMP_W-1:0]       stamp_ff;
   logic [PS_W-1:0]                    pay_ff;

   logic [EW-1:0]                      entry_mem_ff [ENTRIES];
   logic [EW-1:0]                      mem_q_ff;
   logic                               mem_we, mem_re;
   logic [AW-1:0]                      mem_wa, mem_ra;
   logic [EW-1:0]                      mem_wdata;

   logic                               rd_pend_ff, rd_pend_in;
   logic                               pend_last_ff, pend_last_in;
   logic [OW-1:0]                      pend_occ_ff, pend_occ_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_kind_ff, rsp_kind_in;
   logic [1:0]                         rsp_status_ff, rsp_status_in;
   logic [1:0]                         rsp_recovery_ff, rsp_recovery_in;
   logic                               rsp_entry_valid_ff, rsp_entry_valid_in;
   logic [vpiq_pkg::ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic [vpiq_pkg::SRC_W-1:0]         rsp_src_ff, rsp_src_in;
   logic [vpiq_pkg::TYPE_W-1:0]        rsp_typ_ff, rsp_typ_in;
   logic [vpiq_pkg::STAMP_W-1:0]       rsp_stamp_ff, rsp_stamp_in;
   logic [vpiq_pkg::PAY_W-1:0]         rsp_pay_ff, rsp_pay_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [OW-1:0]                      rsp_occ_ff, rsp_occ_in;

   vpiq_pkg::screen_type               screen;

   logic                               req_accept;
   logic                               out_can_load;
   logic                               issue;
   logic                               load_mem;
   logic [QW-1:0]                      q_in;
   logic [QW-1:0]                      qsel;
   logic [LW-1:0]                      limit_eff;
   logic [vpiq_pkg::AGE_W-1:0]         age_lim;
   logic                               stale;
   logic                               full;
   logic [TW-1:0]                      tail_sum;
   logic [PTR_W-1:0]                   tail_ptr;
   logic [OW-1:0]                      cnt_sum;

   assign req_ready    = (state_ff == S_IDLE);
   assign req_accept   = req_valid && req_ready;
   assign out_can_load = !rsp_valid_ff || rsp_ready;
   assign load_mem     = rd_pend_ff && out_can_load;

   vpiq_screen u_screen (
      .clock           (clock),
      .load            (req_accept),
      .source          (req_source),
      .msg_type        (req_msg_type),
      .stamp           (req_stamp),
      .now_time        (req_now_time),
      .schema          (req_schema),
      .seq_no          (req_seq_no),
      .payload_present (req_payload_present),
      .expected_schema (exp_schema_ff),
      .screen          (screen)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_schema_ff  <= vpiq_pkg::RST_EXPECTED_SCHEMA;
         safety_age_ff  <= vpiq_pkg::RST_SAFETY_MAX_AGE;
         default_age_ff <= vpiq_pkg::RST_DEFAULT_MAX_AGE;
         limit_ff       <= vpiq_pkg::RST_QUEUE_LIMIT;
      end else if (csr_we) begin
         case (csr_index)
            vpiq_pkg::CSR_EXPECTED_SCHEMA: begin
               exp_schema_ff <= csr_wdata[vpiq_pkg::SCHEMA_W-1:0];
            end
            vpiq_pkg::CSR_SAFETY_MAX_AGE: begin
               safety_age_ff <= csr_wdata[vpiq_pkg::AGE_W-1:0];
            end
            vpiq_pkg::CSR_DEFAULT_MAX_AGE: begin
               default_age_ff <= csr_wdata[vpiq_pkg::AGE_W-1:0];
            end
            vpiq_pkg::CSR_QUEUE_LIMIT: begin
               limit_ff <= csr_wdata[vpiq_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      q_in = (req_source < vpiq_pkg::SRC_W'(vpiq_pkg::OTHER_QUEUE))
             ? req_source[QW-1:0] : vpiq_pkg::OTHER_QUEUE;

      if (limit_ff == '0) begin
         limit_eff = LW'(1);
      end else if (LW'(limit_ff) > LW'(QUEUE_DEPTH)) begin
         limit_eff = LW'(QUEUE_DEPTH);
      end else begin
         limit_eff = LW'(limit_ff);
      end

      age_lim = screen.safety ? safety_age_ff : default_age_ff;
      stale   = screen.late ||
                (screen.age[vpiq_pkg::STAMP_W-1:vpiq_pkg::AGE_W] != '0) ||
                (screen.age[vpiq_pkg::AGE_W-1:0] > age_lim);
      full    = (LW'(counts_ff[q_ff]) >= limit_eff);

      tail_sum = TW'(heads_ff[q_ff]) + TW'(counts_ff[q_ff]);
      if (tail_sum >= TW'(QUEUE_DEPTH)) begin
         tail_ptr = PTR_W'(tail_sum - TW'(QUEUE_DEPTH));
      end else begin
         tail_ptr = PTR_W'(tail_sum);
      end

      qsel = vpiq_pkg::OTHER_QUEUE;
      for (int q = NQ - 1; q >= 0; q--) begin
         if (counts_ff[q] != '0) begin
            qsel = QW'(q);
         end
      end
   end

   // control and bookkeeping
   always_comb begin
      state_in     = state_ff;
      heads_in     = heads_ff;
      counts_in    = counts_ff;
      id_in        = id_ff;
      occ_in       = occ_ff;
      rd_pend_in   = rd_pend_ff;
      pend_last_in = pend_last_ff;
      pend_occ_in  = pend_occ_ff;
      issue        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wa       = AW'(q_ff) * AW'(QUEUE_DEPTH) + AW'(tail_ptr);
      mem_ra       = AW'(qsel) * AW'(QUEUE_DEPTH) + AW'(heads_ff[qsel]);
      mem_wdata    = {id_ff, stamp_ff, pay_ff, src_ff, typ_ff};

      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_kind_in        = rsp_kind_ff;
      rsp_status_in      = rsp_status_ff;
      rsp_recovery_in    = rsp_recovery_ff;
      rsp_entry_valid_in = rsp_entry_valid_ff;
      rsp_id_in          = rsp_id_ff;
      rsp_src_in         = rsp_src_ff;
      rsp_typ_in         = rsp_typ_ff;
      rsp_stamp_in       = rsp_stamp_ff;
      rsp_pay_in         = rsp_pay_ff;
      rsp_last_in        = rsp_last_ff;
      rsp_occ_in         = rsp_occ_ff;

      if (load_mem) begin
         rd_pend_in         = 1'b0;
         rsp_valid_in       = 1'b1;
         rsp_kind_in        = vpiq_pkg::KIND_ENTRY;
         rsp_status_in      = vpiq_pkg::ST_ACCEPTED;
         rsp_recovery_in    = vpiq_pkg::RC_IGNORE;
         rsp_entry_valid_in = 1'b1;
         rsp_id_in          = mem_q_ff[ID_LSB +: vpiq_pkg::ID_W];
         rsp_src_in         = mem_q_ff[PAY_LSB-1 -: vpiq_pkg::SRC_W];
         rsp_typ_in         = mem_q_ff[CODE_LSB +: vpiq_pkg::TYPE_W];
         rsp_stamp_in       = mem_q_ff[STAMP_LSB +: vpiq_pkg::STAMP_W];
         rsp_pay_in         = vpiq_pkg::PAY_W'(mem_q_ff[PAY_LSB +: PS_W]);
         rsp_last_in        = pend_last_ff;
         rsp_occ_in         = pend_occ_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_type == vpiq_pkg::REQ_PUSH) begin
                  state_in = S_DECIDE;
               end else if (occ_ff == '0) begin
                  state_in = S_EMPTY;
               end else begin
                  state_in = S_DRAIN;
               end
            end
         end
         S_DECIDE: begin
            if (out_can_load) begin
               state_in           = S_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_kind_in        = vpiq_pkg::KIND_STATUS;
               rsp_entry_valid_in = 1'b0;
               rsp_id_in          = '0;
               rsp_src_in         = '0;
               rsp_typ_in         = '0;
               rsp_stamp_in       = '0;
               rsp_pay_in         = '0;
               rsp_last_in        = 1'b1;
               rsp_occ_in         = occ_ff;
               if (screen.bad || stale) begin
                  rsp_status_in   = screen.bad ? vpiq_pkg::ST_INVALID
                                               : vpiq_pkg::ST_STALE;
                  rsp_recovery_in = screen.safety ? vpiq_pkg::RC_SAFE_STOP
                                                  : vpiq_pkg::RC_IGNORE;
               end else if (full) begin
                  rsp_status_in   = vpiq_pkg::ST_OVERFLOW;
                  rsp_recovery_in = vpiq_pkg::RC_RETRY;
               end else begin
                  rsp_status_in     = vpiq_pkg::ST_ACCEPTED;
                  rsp_recovery_in   = vpiq_pkg::RC_IGNORE;
                  rsp_id_in         = id_ff;
                  rsp_occ_in        = occ_ff + OW'(1);
                  mem_we            = 1'b1;
                  counts_in[q_ff]   = counts_ff[q_ff] + CW'(1);
                  id_in             = id_ff + vpiq_pkg::ID_W'(1);
                  occ_in            = occ_ff + OW'(1);
               end
            end
         end
         S_EMPTY: begin
            if (out_can_load) begin
               state_in           = S_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_kind_in        = vpiq_pkg::KIND_ENTRY;
               rsp_status_in      = vpiq_pkg::ST_ACCEPTED;
               rsp_recovery_in    = vpiq_pkg::RC_IGNORE;
               rsp_entry_valid_in = 1'b0;
               rsp_id_in          = '0;
               rsp_src_in         = '0;
               rsp_typ_in         = '0;
               rsp_stamp_in       = '0;
               rsp_pay_in         = '0;
               rsp_last_in        = 1'b1;
               rsp_occ_in         = '0;
            end
         end
         S_DRAIN: begin
            issue = !rd_pend_ff || out_can_load;
            if (issue) begin
               mem_re          = 1'b1;
               rd_pend_in      = 1'b1;
               pend_last_in    = (occ_ff == OW'(1));
               pend_occ_in     = occ_ff - OW'(1);
               occ_in          = occ_ff - OW'(1);
               counts_in[qsel] = counts_ff[qsel] - CW'(1);
               heads_in[qsel]  = (heads_ff[qsel] == PTR_W'(QUEUE_DEPTH - 1))
                                 ? '0 : heads_ff[qsel] + PTR_W'(1);
               if (occ_ff == OW'(1)) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (load_mem) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         id_ff        <= '0;
         occ_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < NQ; q++) begin
            heads_ff[q]  <= '0;
            counts_ff[q] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         id_ff        <= id_in;
         occ_ff       <= occ_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
         counts_ff    <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff       <= pend_last_in;
      pend_occ_ff        <= pend_occ_in;
      rsp_kind_ff        <= rsp_kind_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_recovery_ff    <= rsp_recovery_in;
      rsp_entry_valid_ff <= rsp_entry_valid_in;
      rsp_id_ff          <= rsp_id_in;
      rsp_src_ff         <= rsp_src_in;
      rsp_typ_ff         <= rsp_typ_in;
      rsp_stamp_ff       <= rsp_stamp_in;
      rsp_pay_ff         <= rsp_pay_in;
      rsp_last_ff        <= rsp_last_in;
      rsp_occ_ff         <= rsp_occ_in;
      if (req_accept) begin
         q_ff     <= q_in;
         src_ff   <= req_source;
         typ_ff   <= req_msg_type;
         stamp_ff <= req_stamp;
         pay_ff   <= req_payload[PS_W-1:0];
      end
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_wa] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= entry_mem_ff[mem_ra];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_recovery      = rsp_recovery_ff;
   assign rsp_entry_valid   = rsp_entry_valid_ff;
   assign rsp_entry_id      = rsp_id_ff;
   assign rsp_entry_source  = rsp_src_ff;
   assign rsp_entry_type    = rsp_typ_ff;
   assign rsp_entry_stamp   = rsp_stamp_ff;
   assign rsp_entry_payload = rsp_pay_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_occupancy     = rsp_occ_ff[vpiq_pkg::OCC_W-1:0];

   always_comb begin
      cnt_sum = '0;
      for (int q = 0; q < NQ; q++) begin
         cnt_sum = cnt_sum + OW'(counts_ff[q]);
      end
   end

   a_occ_matches_counts: assert property (@(posedge clock) disable iff (reset)
      occ_ff == cnt_sum)
      else $error("occupancy differs from sum of queue counts");

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(ENTRIES))
      else $error("occupancy above storage size");

   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rd_pend_ff)
      else $error("accepting while a memory read is in flight");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (occ_ff != '0))
      else $error("drain with no stored entries");

   a_flush_ends_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> (occ_ff == '0 && rd_pend_ff && pend_last_ff))
      else $error("final drain read not marked last");

endmodule
